// ===== sv/sfhp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfhp_pkg
// Types and constants for the serial frame header parser.
// ----------------------------------------------------------------------------
package sfhp_pkg;

	localparam logic [7:0]  TS_TYPE     = 8'h3d;
	localparam logic [31:0] TS_SENTINEL = 32'h0800_0000;
	localparam int          HDR_BYTES   = 8;
	localparam int          TS_TAIL     = 5;
	localparam logic [8:0]  POS_MAX     = 9'd511;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_TYPE  = 3'd1,
		ST_SHORT_HDR = 3'd2,
		ST_LEN_MISM  = 3'd3,
		ST_SHORT_TS  = 3'd4
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_RECORD  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         payload_byte;
		logic [15:0]        dst_addr;
		logic [15:0]        src_addr;
		logic [7:0]         group_id;
		logic [7:0]         msg_type;
		logic signed [31:0] sync_offset;
		logic               sync_valid;
		status_t            status;
		logic               end_of_run;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/serial_frame_header_parser.sv =====
`default_nettype none
// A result is registered into the result queue when its request is taken.
// One byte request per cycle while input ready is high; each byte yields at most two results
// (payload, then end-of-frame record), drained from a 4-entry queue one per cycle while out_ready is high.
// Input ready drops only while fewer than two queue slots are free.
// Reset (arst_n low, asynchronous): frame state cleared, ignore_foreign = 0,
// result queue empty.
// ----------------------------------------------------------------------------
// serial_frame_header_parser
// Byte-serial frame header parser: captures the header, streams payload bytes
// and emits an end-of-frame record with header fields and a status.
// ----------------------------------------------------------------------------
module serial_frame_header_parser
	import sfhp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	// byte requests
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	// results
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    kind,
	output logic [7:0]              payload_byte,
	output logic [15:0]             dst_addr,
	output logic [15:0]             src_addr,
	output logic [7:0]              group_id,
	output logic [7:0]              msg_type,
	output logic signed [31:0]      sync_offset,
	output logic                    sync_valid,
	output logic [2:0]              status,
	output logic                    end_of_run
);

	// Frame state
	logic        ign_q;
	logic [8:0]  pos_q;
	logic [7:0]  len_q;
	logic [15:0] dst_q;
	logic [15:0] src_q;
	logic [7:0]  grp_q;
	logic [7:0]  typ_q;
	logic [31:0] off_q;
	logic        err_q;
	logic        drop_q;
	logic        ts_q;

	// Result queue
	result_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	logic accept;
	logic pop;

	// Next-state and result values for the byte being taken
	logic        first;
	logic [8:0]  pos_n;
	logic [7:0]  len_n;
	logic [15:0] dst_n;
	logic [15:0] src_n;
	logic [7:0]  grp_n;
	logic [7:0]  typ_n;
	logic [31:0] off_n;
	logic        err_n;
	logic        drop_n;
	logic        ts_n;
	logic        pay;
	logic        rec;
	logic [9:0]  tail;
	logic [9:0]  size;
	status_t     st;
	result_t     pay_res;
	result_t     rec_res;

	assign accept = in_valid && in_ready;
	assign pop    = out_valid && out_ready;
	// Always leave room for a payload result and a record
	assign in_ready  = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign out_valid = (cnt_q != '0);

	always_comb begin
		first = (pos_q == '0);

		// Start of frame: drop any leftover header state and vet byte zero
		len_n  = first ? '0 : len_q;
		dst_n  = first ? '0 : dst_q;
		src_n  = first ? '0 : src_q;
		grp_n  = first ? '0 : grp_q;
		typ_n  = first ? '0 : typ_q;
		ts_n   = first ? 1'b0 : ts_q;
		err_n  = first ? ((data_byte != 8'd0) && !ign_q) : err_q;
		drop_n = first ? ((data_byte != 8'd0) && ign_q) : drop_q;
		off_n  = first ? {24'd0, data_byte} : {off_q[23:0], data_byte};

		// Header capture, big-endian addresses
		case (pos_q)
			9'd1: dst_n[15:8] = data_byte;
			9'd2: dst_n[7:0]  = data_byte;
			9'd3: src_n[15:8] = data_byte;
			9'd4: src_n[7:0]  = data_byte;
			9'd5: len_n       = data_byte;
			9'd6: grp_n       = data_byte;
			9'd7: begin
				typ_n = data_byte;
				ts_n  = (data_byte == TS_TYPE);
			end
			default: ;
		endcase

		// Payload window; a timesync frame keeps its five-byte tail back,
		// and the first tail byte carries the real message type
		tail = {2'b00, len_n} + 10'(HDR_BYTES - TS_TAIL);
		pay  = 1'b0;
		if ((pos_q >= 9'(HDR_BYTES)) && !drop_n) begin
			pay = 1'b1;
			if (ts_n) begin
				if ({1'b0, pos_q} == tail)
					typ_n = data_byte;
				pay = ({1'b0, pos_q} < tail);
			end
		end

		// End-of-frame record
		rec  = last_byte && !drop_n;
		size = {1'b0, pos_q} + 10'd1;
		if (err_n)
			st = ST_BAD_TYPE;
		else if (size < 10'(HDR_BYTES))
			st = ST_SHORT_HDR;
		else if (({2'b00, len_n} + 10'(HDR_BYTES)) != size)
			st = ST_LEN_MISM;
		else if (ts_n && (len_n < 8'(TS_TAIL)))
			st = ST_SHORT_TS;
		else
			st = ST_OK;

		pay_res              = '0;
		pay_res.kind         = KIND_PAYLOAD;
		pay_res.payload_byte = data_byte;
		pay_res.end_of_run   = !rec;

		rec_res             = '0;
		rec_res.kind        = KIND_RECORD;
		rec_res.dst_addr    = dst_n;
		rec_res.src_addr    = src_n;
		rec_res.group_id    = grp_n;
		rec_res.msg_type    = typ_n;
		rec_res.sync_offset = ts_n ? off_n : '0;
		rec_res.sync_valid  = ts_n && (off_n != TS_SENTINEL);
		rec_res.status      = st;
		rec_res.end_of_run  = 1'b1;

		// Saturating byte position, back to zero after the last byte
		if (last_byte)
			pos_n = '0;
		else
			pos_n = (pos_q < POS_MAX) ? pos_q + 9'd1 : POS_MAX;
	end

	// Configuration and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_q  <= 1'b0;
			pos_q  <= '0;
			len_q  <= '0;
			dst_q  <= '0;
			src_q  <= '0;
			grp_q  <= '0;
			typ_q  <= '0;
			off_q  <= '0;
			err_q  <= 1'b0;
			drop_q <= 1'b0;
			ts_q   <= 1'b0;
		end else begin
			if (cfg_we)
				ign_q <= cfg_wdata;
			if (accept) begin
				pos_q <= pos_n;
				if (last_byte) begin
					// Clear frame state once the record has been queued
					len_q  <= '0;
					dst_q  <= '0;
					src_q  <= '0;
					grp_q  <= '0;
					typ_q  <= '0;
					off_q  <= '0;
					err_q  <= 1'b0;
					drop_q <= 1'b0;
					ts_q   <= 1'b0;
				end else begin
					len_q  <= len_n;
					dst_q  <= dst_n;
					src_q  <= src_n;
					grp_q  <= grp_n;
					typ_q  <= typ_n;
					off_q  <= off_n;
					err_q  <= err_n;
					drop_q <= drop_n;
					ts_q   <= ts_n;
				end
			end
		end
	end

	// Queue storage: payload first, record in the slot after it
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pay)
				fifo_q[wp_q] <= pay_res;
			if (rec)
				fifo_q[wp_q + PTR_W'(pay)] <= rec_res;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept)
				wp_q <= wp_q + PTR_W'(pay) + PTR_W'(rec);
			if (pop)
				rp_q <= rp_q + PTR_W'(1);
			cnt_q <= cnt_q + (accept ? (CNT_W'(pay) + CNT_W'(rec)) : '0)
				- CNT_W'(pop);
		end
	end

	assign kind         = fifo_q[rp_q].kind;
	assign payload_byte = fifo_q[rp_q].payload_byte;
	assign dst_addr     = fifo_q[rp_q].dst_addr;
	assign src_addr     = fifo_q[rp_q].src_addr;
	assign group_id     = fifo_q[rp_q].group_id;
	assign msg_type     = fifo_q[rp_q].msg_type;
	assign sync_offset  = fifo_q[rp_q].sync_offset;
	assign sync_valid   = fifo_q[rp_q].sync_valid;
	assign status       = fifo_q[rp_q].status;
	assign end_of_run   = fifo_q[rp_q].end_of_run;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != CNT_W'(FIFO_DEPTH)) |-> (wp_q - rp_q) == cnt_q[PTR_W-1:0])
		else $error("queue pointers disagree with fill count");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (pos_q == '0) && !drop_q && !err_q)
		else $error("frame state not cleared after last byte");

	a_record_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (payload_byte == 8'd0) && end_of_run)
		else $error("malformed end-of-frame record");
`endif

endmodule
`default_nettype wire

// ===== tb/serial_frame_header_parser_test.sv =====
// ----------------------------------------------------------------------------
// serial_frame_header_parser_test
// Feeds byte-serial frames into the header parser and checks every payload
// byte and end-of-frame record against an in-bench parser model. Directed
// frames cover header extremes, timesync tails and every status. Random
// traffic mixes good frames with broken ones under both foreign-frame
// settings, and random stalls on both sides.
// ----------------------------------------------------------------------------
module serial_frame_header_parser_test
	import sfhp_pkg::*;
();

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic               cfg_wdata    = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [7:0]         data_byte    = 8'h00;
	logic               last_byte    = 1'b0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic               kind;
	logic [7:0]         payload_byte;
	logic [15:0]        dst_addr;
	logic [15:0]        src_addr;
	logic [7:0]         group_id;
	logic [7:0]         msg_type;
	logic signed [31:0] sync_offset;
	logic               sync_valid;
	logic [2:0]         status;
	logic               end_of_run;

	// Parser model state, mirrors what the block tracks per frame
	logic [8:0]  frame_pos   = '0;
	logic [7:0]  len_q       = '0;
	logic [15:0] dst_q       = '0;
	logic [15:0] src_q       = '0;
	logic [7:0]  grp_q       = '0;
	logic [7:0]  typ_q       = '0;
	logic [31:0] tail_shift  = '0;
	bit          bad_lead    = 1'b0;
	bit          drop_frame  = 1'b0;
	bit          ts_frame    = 1'b0;
	bit          ignore_cfg  = 1'b0;

	// Results the parser still owes us, oldest first
	result_t     parse_results[$];
	// Frame under construction by the stimulus tasks
	logic [7:0]  frame_buf[$];

	int          mismatch_count = 0;
	int          bytes_sent     = 0;
	// Set to run a stretch with both sides streaming at full rate
	bit          no_stall       = 1'b0;

	serial_frame_header_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.dst_addr     (dst_addr),
		.src_addr     (src_addr),
		.group_id     (group_id),
		.msg_type     (msg_type),
		.sync_offset  (sync_offset),
		.sync_valid   (sync_valid),
		.status       (status),
		.end_of_run   (end_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side back-pressure: stall about 15% of cycles unless streaming
	always @(negedge clk) begin
		out_ready <= no_stall || ($urandom_range(99) >= 15);
	end

	// Drop all per-frame state; done on the first byte and after the last one
	task automatic clear_frame();
		frame_pos  = '0;
		len_q      = '0;
		dst_q      = '0;
		src_q      = '0;
		grp_q      = '0;
		typ_q      = '0;
		tail_shift = '0;
		bad_lead   = 1'b0;
		drop_frame = 1'b0;
		ts_frame   = 1'b0;
	endtask

	// Advance the parser model by one accepted byte and queue what it yields
	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [8:0] pos;
		int         tail_pos;
		int         size;
		bit         pay;
		result_t    r;
		result_t    step_out[$];
		status_t    st;
		pos = frame_pos;
		if (pos == 9'd0) begin
			clear_frame();
			// a nonzero lead byte marks a foreign frame
			if (b != 8'h00) begin
				if (ignore_cfg)
					drop_frame = 1'b1;
				else
					bad_lead = 1'b1;
			end
		end
		// the last four bytes seen form the timesync offset, big-endian
		tail_shift = {tail_shift[23:0], b};
		case (pos)
			9'd1: dst_q[15:8] = b;
			9'd2: dst_q[7:0]  = b;
			9'd3: src_q[15:8] = b;
			9'd4: src_q[7:0]  = b;
			9'd5: len_q       = b;
			9'd6: grp_q       = b;
			9'd7: begin
				typ_q    = b;
				ts_frame = (b == TS_TYPE);
			end
			default: ;
		endcase
		if (int'(pos) >= HDR_BYTES && !drop_frame) begin
			// timesync frames hold back their five tail bytes; the first of
			// them is the real message type
			tail_pos = int'(len_q) + HDR_BYTES - TS_TAIL;
			pay = 1'b1;
			if (ts_frame) begin
				if (int'(pos) == tail_pos)
					typ_q = b;
				pay = (int'(pos) < tail_pos);
			end
			if (pay) begin
				r = '0;
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b;
				step_out = {step_out, r};
			end
		end
		if (last) begin
			if (!drop_frame) begin
				// status checks run in priority order
				size = int'(pos) + 1;
				if (bad_lead)
					st = ST_BAD_TYPE;
				else if (size < HDR_BYTES)
					st = ST_SHORT_HDR;
				else if (int'(len_q) + HDR_BYTES != size)
					st = ST_LEN_MISM;
				else if (ts_frame && int'(len_q) < TS_TAIL)
					st = ST_SHORT_TS;
				else
					st = ST_OK;
				r = '0;
				r.kind        = KIND_RECORD;
				r.dst_addr    = dst_q;
				r.src_addr    = src_q;
				r.group_id    = grp_q;
				r.msg_type    = typ_q;
				r.sync_offset = ts_frame ? tail_shift : 32'd0;
				r.sync_valid  = ts_frame && (tail_shift != TS_SENTINEL);
				r.status      = st;
				step_out = {step_out, r};
			end
			clear_frame();
		end else begin
			// position saturates on overlong frames
			frame_pos = (pos < POS_MAX) ? pos + 9'd1 : POS_MAX;
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].end_of_run = 1'b1;
		foreach (step_out[i])
			parse_results = {parse_results, step_out[i]};
	endtask

	// Present one byte request and hold it until the parser takes it
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		// random input gaps, one assignment per falling edge
		while (!no_stall && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		parse_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Assemble a frame: header, then body_len bytes. For a timesync type with
	// room for it, the body ends in the real type byte and a big-endian offset.
	task automatic build_frame(input logic [7:0] lead, input logic [15:0] dst,
			input logic [15:0] src, input logic [7:0] len, input logic [7:0] grp,
			input logic [7:0] typ, input int body_len, input logic [7:0] real_typ,
			input logic [31:0] offs);
		int tail_at;
		frame_buf = {};
		frame_buf = {frame_buf, lead};
		frame_buf = {frame_buf, dst[15:8]};
		frame_buf = {frame_buf, dst[7:0]};
		frame_buf = {frame_buf, src[15:8]};
		frame_buf = {frame_buf, src[7:0]};
		frame_buf = {frame_buf, len};
		frame_buf = {frame_buf, grp};
		frame_buf = {frame_buf, typ};
		tail_at = body_len - TS_TAIL;
		for (int i = 0; i < body_len; i++) begin
			if (typ == TS_TYPE && tail_at >= 0 && i == tail_at)
				frame_buf = {frame_buf, real_typ};
			else if (typ == TS_TYPE && tail_at >= 0 && i > tail_at)
				frame_buf = {frame_buf, offs[8 * (body_len - 1 - i) +: 8]};
			else
				frame_buf = {frame_buf, 8'($urandom_range(255))};
		end
	endtask

	// Cut the frame short, so the last byte lands early
	task automatic trim_frame(input int n);
		while (frame_buf.size() > n)
			void'(frame_buf.pop_back());
	endtask

	// Drop valid, wait for every owed result, then let the pipe settle; frames
	// that yield nothing may still be in flight when the queue runs dry
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (parse_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_ignore_foreign(input logic v);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		ignore_cfg = v;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (parse_results.size() == 0) begin
				$error("unexpected result: kind %0d, payload_byte %0h, status %0d",
					kind, payload_byte, status);
				mismatch_count++;
			end else begin
				want = parse_results.pop_front();
				check_field("kind",         want.kind,         kind);
				check_field("payload_byte", want.payload_byte, payload_byte);
				check_field("dst_addr",     want.dst_addr,     dst_addr);
				check_field("src_addr",     want.src_addr,     src_addr);
				check_field("group_id",     want.group_id,     group_id);
				check_field("msg_type",     want.msg_type,     msg_type);
				check_field("sync_offset",  want.sync_offset,  sync_offset);
				check_field("sync_valid",   want.sync_valid,   sync_valid);
				check_field("status",       want.status,       status);
				check_field("end_of_run",   want.end_of_run,   end_of_run);
			end
		end
	end

	// Clean frames with header fields at their extremes
	task automatic test_header_fields();
		build_frame(8'h00, 16'hffff, 16'h0000, 8'd0, 8'h00, 8'hff, 0, 8'h00, 32'd0);
		send_frame();
		build_frame(8'h00, 16'h0000, 16'hffff, 8'd3, 8'hff, 8'h00, 3, 8'h00, 32'd0);
		send_frame();
		wait_drained();
	endtask

	// Timesync tails: offset extremes, the sentinel offset, and a length too
	// short to carry the tail
	task automatic test_timesync();
		build_frame(8'h00, 16'h1234, 16'h5678, 8'd5, 8'h22, TS_TYPE, 5,
			8'hff, 32'h8000_0000);
		send_frame();
		build_frame(8'h00, 16'h8001, 16'h7ffe, 8'd7, 8'h01, TS_TYPE, 7,
			8'h00, 32'h7fff_ffff);
		send_frame();
		build_frame(8'h00, 16'h0102, 16'h0304, 8'd5, 8'h05, TS_TYPE, 5,
			8'h3d, TS_SENTINEL);
		send_frame();
		build_frame(8'h00, 16'h0a0b, 16'h0c0d, 8'd4, 8'h06, TS_TYPE, 4,
			8'h00, 32'd0);
		send_frame();
		wait_drained();
	endtask

	// Short header, single byte, length mismatch both ways, reported foreign
	// frames, and a timesync frame that ends before its tail
	task automatic test_frame_errors();
		build_frame(8'h00, 16'habcd, 16'h0000, 8'd0, 8'h00, 8'h00, 0, 8'h00, 32'd0);
		trim_frame(3);
		send_frame();
		send_byte(8'h00, 1'b1);
		build_frame(8'h00, 16'h1111, 16'h2222, 8'd1, 8'h33, 8'h44, 3, 8'h00, 32'd0);
		send_frame();
		build_frame(8'h00, 16'h5555, 16'h6666, 8'd4, 8'h77, 8'h88, 0, 8'h00, 32'd0);
		send_frame();
		build_frame(8'hff, 16'h9999, 16'haaaa, 8'd2, 8'hbb, 8'hcc, 2, 8'h00, 32'd0);
		send_frame();
		send_byte(8'h80, 1'b1);
		build_frame(8'h00, 16'h0f0f, 16'hf0f0, 8'd5, 8'h10, TS_TYPE, 5,
			8'h20, 32'h1234_5678);
		trim_frame(8);
		send_frame();
		wait_drained();
	endtask

	// With foreign frames ignored, drop them silently; good frames still pass
	task automatic test_ignore_foreign();
		write_ignore_foreign(1'b1);
		build_frame(8'h01, 16'h1357, 16'h2468, 8'd2, 8'h42, 8'h43, 2, 8'h00, 32'd0);
		send_frame();
		send_byte(8'hff, 1'b1);
		build_frame(8'h00, 16'hcafe, 16'hbeef, 8'd1, 8'h07, 8'h08, 1, 8'h00, 32'd0);
		send_frame();
		build_frame(8'h00, 16'h0001, 16'h0002, 8'd0, 8'h00, 8'h00, 0, 8'h00, 32'd0);
		trim_frame(5);
		send_frame();
		write_ignore_foreign(1'b0);
	endtask

	// One random frame: mostly well formed, the rest broken in various ways
	task automatic send_random_frame();
		int          pick;
		int          len;
		int          body;
		logic [7:0]  typ;
		logic [7:0]  lead;
		logic [31:0] offs;
		pick = $urandom_range(99);
		typ  = ($urandom_range(3) == 0) ? TS_TYPE : 8'($urandom_range(255));
		// keep most frames small, with the odd long one
		len  = ($urandom_range(49) == 0) ? $urandom_range(255) : $urandom_range(12);
		if (typ == TS_TYPE && len < TS_TAIL && $urandom_range(3) != 0)
			len = len + TS_TAIL;
		offs = ($urandom_range(5) == 0) ? TS_SENTINEL : 32'($urandom);
		lead = 8'h00;
		body = len;
		if (pick >= 62 && pick < 74)
			body = $urandom_range(20);
		else if (pick >= 74 && pick < 84)
			lead = 8'($urandom_range(1, 255));
		build_frame(lead, 16'($urandom), 16'($urandom), 8'(len), 8'($urandom),
			typ, body, 8'($urandom), offs);
		if (pick >= 84 && pick < 92) begin
			trim_frame($urandom_range(1, 7));
		end else if (pick >= 92) begin
			// plain noise of random length and content
			frame_buf = {};
			repeat ($urandom_range(1, 20))
				frame_buf = {frame_buf, 8'($urandom)};
		end
		send_frame();
	endtask

	// Random traffic in phases: reported foreign frames with stalls, ignored
	// foreign frames at full rate, then reported again with stalls
	task automatic test_random_traffic();
		int stop_at;
		stop_at = bytes_sent + 250;
		while (bytes_sent < stop_at)
			send_random_frame();
		write_ignore_foreign(1'b1);
		no_stall = 1'b1;
		stop_at = bytes_sent + 170;
		while (bytes_sent < stop_at)
			send_random_frame();
		wait_drained();
		no_stall = 1'b0;
		write_ignore_foreign(1'b0);
		stop_at = bytes_sent + 250;
		while (bytes_sent < stop_at)
			send_random_frame();
		wait_drained();
	endtask

	// Frames past 512 bytes: position saturates, extra bytes of a non-timesync frame stream as payload
	task automatic test_overlong_frame();
		build_frame(8'h00, 16'h4321, 16'h8765, 8'd10, 8'h99, 8'h11, 515,
			8'h00, 32'd0);
		send_frame();
		build_frame(8'h00, 16'hfedc, 16'hba98, 8'd255, 8'h66, TS_TYPE, 510,
			8'h55, 32'hdead_beef);
		send_frame();
		wait_drained();
	endtask

	initial begin
		// hold reset, then release it on a falling edge
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_header_fields();
		test_timesync();
		test_frame_errors();
		test_ignore_foreign();
		test_random_traffic();
		test_overlong_frame();
		wait_drained();
		if (mismatch_count == 0)
			$display("serial_frame_header_parser_test: done, clean");
		else
			$display("serial_frame_header_parser_test: done, errors");
		$finish;
	end

	// Hang guard: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("serial_frame_header_parser_test: done, errors");
		$finish;
	end

endmodule
